[hw/rtl/fabg_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fabg_pkg
// Shared types and codes of the frame aware boost governor.
// ----------------------------------------------------------------------------
package fabg_pkg;

    localparam int NOW_W   = 48;
    localparam int BOOST_W = 7;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 4;

    typedef enum logic [2:0] {
        KIND_TICK       = 3'd0,
        KIND_TOUCH_DOWN = 3'd1,
        KIND_TOUCH_MOVE = 3'd2,
        KIND_COMMIT     = 3'd3,
        KIND_DISP_ON    = 3'd4,
        KIND_DISP_OFF   = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_TAP    = 2'd1,
        MODE_SCROLL = 2'd2,
        MODE_FLING  = 2'd3
    } t_mode;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_PERIOD   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MISS_THRESHOLD = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FLING_INTERVAL = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_LEVEL      = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCROLL_LEVEL   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FLING_LEVEL    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BOOST_MISS     = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_MAX       = 4'd7;

    typedef struct packed {
        logic [CFG_W-1:0]   frame_period;
        logic [CFG_W-1:0]   miss_threshold;
        logic [CFG_W-1:0]   fling_interval;
        logic [BOOST_W-1:0] tap_level;
        logic [BOOST_W-1:0] scroll_level;
        logic [BOOST_W-1:0] fling_level;
        logic [BOOST_W-1:0] boost_miss;
        logic [BOOST_W-1:0] step_max;
    } t_cfg;

    typedef struct packed {
        logic [BOOST_W-1:0] boost;
        t_mode              mode;
        logic               idle_fired;
        logic               frame_missed;
    } t_res;

endpackage
`default_nettype wire

[hw/rtl/fabg_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fabg_evt_if / fabg_res_if
// Valid/ready channels for events in and boost results out.
// ----------------------------------------------------------------------------
interface fabg_evt_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [47:0] now;

    modport source (output valid, output kind, output now, input ready);
    modport sink   (input valid, input kind, input now, output ready);
endinterface

interface fabg_res_if;
    logic       valid;
    logic       ready;
    logic [6:0] boost;
    logic [1:0] mode;
    logic       idle_fired;
    logic       frame_missed;

    modport source (output valid, output boost, output mode, output idle_fired,
                    output frame_missed, input ready);
    modport sink   (input valid, input boost, input mode, input idle_fired,
                    input frame_missed, output ready);
endinterface
`default_nettype wire

[hw/rtl/fabg_cfg_regs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fabg_cfg_regs
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module fabg_cfg_regs (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [fabg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [fabg_pkg::CFG_W-1:0]      i_cfg_data,
    output fabg_pkg::t_cfg                       o_cfg
);

    fabg_pkg::t_cfg r_cfg;
    fabg_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                fabg_pkg::REG_FRAME_PERIOD:   n_cfg.frame_period   = i_cfg_data;
                fabg_pkg::REG_MISS_THRESHOLD: n_cfg.miss_threshold = i_cfg_data;
                fabg_pkg::REG_FLING_INTERVAL: n_cfg.fling_interval = i_cfg_data;
                fabg_pkg::REG_TAP_LEVEL:
                    n_cfg.tap_level    = i_cfg_data[fabg_pkg::BOOST_W-1:0];
                fabg_pkg::REG_SCROLL_LEVEL:
                    n_cfg.scroll_level = i_cfg_data[fabg_pkg::BOOST_W-1:0];
                fabg_pkg::REG_FLING_LEVEL:
                    n_cfg.fling_level  = i_cfg_data[fabg_pkg::BOOST_W-1:0];
                fabg_pkg::REG_BOOST_MISS:
                    n_cfg.boost_miss   = i_cfg_data[fabg_pkg::BOOST_W-1:0];
                fabg_pkg::REG_STEP_MAX:
                    n_cfg.step_max     = i_cfg_data[fabg_pkg::BOOST_W-1:0];
                default: begin
                    // unknown index: write dropped
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_period   <= 32'd16666666;
            r_cfg.miss_threshold <= 32'd20000000;
            r_cfg.fling_interval <= 32'd8000000;
            r_cfg.tap_level      <= 7'd10;
            r_cfg.scroll_level   <= 7'd20;
            r_cfg.fling_level    <= 7'd30;
            r_cfg.boost_miss     <= 7'd50;
            r_cfg.step_max       <= 7'd10;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

[hw/rtl/fabg_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fabg_core
// Governor state and the single-pass event step: idle expiry, touch mode
// selection, miss check, display on/off and the rate-limited boost update.
// ----------------------------------------------------------------------------
module fabg_core #(
    parameter int TIME_BITS = 48
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic [2:0]                   i_kind,
    input  wire logic [fabg_pkg::NOW_W-1:0]   i_now,
    input  fabg_pkg::t_cfg                    i_cfg,
    output fabg_pkg::t_res                    o_res
);

    localparam int NW = fabg_pkg::NOW_W;
    localparam int BW = fabg_pkg::BOOST_W;
    localparam int WW = (TIME_BITS > NW) ? TIME_BITS : NW;

    fabg_pkg::t_mode r_mode, n_mode;
    logic [NW-1:0]   r_last_frame, n_last_frame;
    logic [NW-1:0]   r_last_input, n_last_input;
    logic [BW-1:0]   r_applied, n_applied;
    logic [BW-1:0]   r_target, n_target;
    logic            r_screen_on, n_screen_on;
    logic            r_armed, n_armed;

    logic [WW-1:0]        frame_diff_w, input_diff_w;
    logic [TIME_BITS-1:0] frame_diff, input_diff;
    logic                 idle_fire, missed, fling;
    logic [BW-1:0]        app_after_idle;
    fabg_pkg::t_mode      touch_mode;
    logic [BW-1:0]        touch_target;

    // move cur toward tgt by at most step
    function automatic logic [BW-1:0] step_toward(input logic [BW-1:0] cur,
                                                 input logic [BW-1:0] tgt,
                                                 input logic [BW-1:0] step);
        logic [BW:0] cur_up;
        logic [BW:0] tgt_up;
        cur_up = {1'b0, cur} + {1'b0, step};
        tgt_up = {1'b0, tgt} + {1'b0, step};
        if ({1'b0, tgt} > cur_up) begin
            step_toward = cur_up[BW-1:0];
        end else if (tgt_up < {1'b0, cur}) begin
            step_toward = cur - step;
        end else begin
            step_toward = tgt;
        end
    endfunction

    always_comb begin
        frame_diff_w = WW'(i_now) - WW'(r_last_frame);
        input_diff_w = WW'(i_now) - WW'(r_last_input);
        frame_diff   = frame_diff_w[TIME_BITS-1:0];
        input_diff   = input_diff_w[TIME_BITS-1:0];

        idle_fire = r_armed && (frame_diff >= TIME_BITS'(i_cfg.frame_period));
        fling = (r_last_input != '0) &&
                (input_diff < TIME_BITS'(i_cfg.fling_interval));
        app_after_idle = idle_fire ? step_toward(r_applied, '0, i_cfg.step_max)
                                   : r_applied;

        if (fabg_pkg::t_kind'(i_kind) == fabg_pkg::KIND_TOUCH_DOWN) begin
            touch_mode   = fabg_pkg::MODE_TAP;
            touch_target = i_cfg.tap_level;
        end else if (fling) begin
            touch_mode   = fabg_pkg::MODE_FLING;
            touch_target = i_cfg.fling_level;
        end else begin
            touch_mode   = fabg_pkg::MODE_SCROLL;
            touch_target = i_cfg.scroll_level;
        end

        n_mode       = idle_fire ? fabg_pkg::MODE_IDLE : r_mode;
        n_target     = idle_fire ? '0 : r_target;
        n_applied    = app_after_idle;
        n_armed      = idle_fire ? 1'b0 : r_armed;
        n_last_frame = r_last_frame;
        n_last_input = r_last_input;
        n_screen_on  = r_screen_on;
        missed       = 1'b0;

        case (fabg_pkg::t_kind'(i_kind))
            fabg_pkg::KIND_TOUCH_DOWN, fabg_pkg::KIND_TOUCH_MOVE: begin
                if (r_screen_on) begin
                    missed = (r_last_frame != '0) &&
                             (frame_diff > TIME_BITS'(i_cfg.miss_threshold));
                    n_mode       = touch_mode;
                    n_target     = missed ? i_cfg.boost_miss : touch_target;
                    n_last_input = i_now;
                    n_last_frame = i_now;
                    n_armed      = 1'b1;
                    n_applied    = step_toward(app_after_idle, n_target,
                                               i_cfg.step_max);
                end
            end
            fabg_pkg::KIND_COMMIT: begin
                missed = (r_last_frame != '0) &&
                         (frame_diff > TIME_BITS'(i_cfg.miss_threshold));
                if (missed) begin
                    n_target = i_cfg.boost_miss;
                end
                n_last_frame = i_now;
                n_armed      = 1'b1;
                n_applied    = step_toward(app_after_idle, n_target, i_cfg.step_max);
            end
            fabg_pkg::KIND_DISP_ON: begin
                n_screen_on = 1'b1;
            end
            fabg_pkg::KIND_DISP_OFF: begin
                n_screen_on = 1'b0;
                n_mode      = fabg_pkg::MODE_IDLE;
                n_applied   = '0;
                n_target    = '0;
                n_armed     = 1'b0;
            end
            default: begin
                // tick and unused kinds: expiry only
                n_screen_on = r_screen_on;
            end
        endcase

        o_res.boost        = n_applied;
        o_res.mode         = n_mode;
        o_res.idle_fired   = idle_fire;
        o_res.frame_missed = missed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= fabg_pkg::MODE_IDLE;
            r_last_frame <= '0;
            r_last_input <= '0;
            r_applied    <= '0;
            r_target     <= '0;
            r_screen_on  <= 1'b0;
            r_armed      <= 1'b0;
        end else if (i_en) begin
            r_mode       <= n_mode;
            r_last_frame <= n_last_frame;
            r_last_input <= n_last_input;
            r_applied    <= n_applied;
            r_target     <= n_target;
            r_screen_on  <= n_screen_on;
            r_armed      <= n_armed;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/frame_aware_boost_governor.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// frame_aware_boost_governor
// Event driven boost governor with tap/scroll/fling modes and idle expiry.
// ----------------------------------------------------------------------------
// Usage:
//   i_evt carries one timestamped event per item (kind, now); o_res returns
//   exactly one result item per event: applied boost, mode, idle and miss
//   flags. Both channels are valid/ready.
//   An accepted item lands in the input register; the event step moves it
//   into the result register, which drives o_res.valid, once that register
//   is empty or its item is taken.
//   Throughput is one item per cycle while o_res is not stalled; the step is
//   a few compares and two chained 7-bit clamps on the state registers.
//   When o_res is stalled the result register holds and one more item waits
//   in the input register; i_evt.ready drops only when both are full.
//   Reset (synchronous, active low) restores register defaults, clears the
//   governor state (idle, boost 0, display off, timer disarmed) and empties
//   both pipeline registers.
//   Configuration (unknown index ignored) goes in via i_cfg_we / i_cfg_idx /
//   i_cfg_data, by the user only while no item is in flight (not enforced).
// ----------------------------------------------------------------------------
module frame_aware_boost_governor #(
    parameter int TIME_BITS = 48
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [fabg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [fabg_pkg::CFG_W-1:0]      i_cfg_data,
    fabg_evt_if.sink                             i_evt,
    fabg_res_if.source                           o_res
);

    fabg_pkg::t_cfg cfg;
    fabg_pkg::t_res core_res;

    logic                       r_in_valid;
    logic [2:0]                 r_in_kind;
    logic [fabg_pkg::NOW_W-1:0] r_in_now;
    logic                       r_out_valid;
    fabg_pkg::t_res             r_out;
    logic                       advance;
    logic                       in_ready;

    assign advance  = !r_out_valid || o_res.ready;
    assign in_ready = !r_in_valid || advance;

    fabg_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    fabg_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance && r_in_valid),
        .i_kind  (r_in_kind),
        .i_now   (r_in_now),
        .i_cfg   (cfg),
        .o_res   (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_evt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_evt.valid) begin
            r_in_kind <= i_evt.kind;
            r_in_now  <= i_evt.now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out <= core_res;
        end
    end

    assign i_evt.ready        = in_ready;
    assign o_res.valid        = r_out_valid;
    assign o_res.boost        = r_out.boost;
    assign o_res.mode         = r_out.mode;
    assign o_res.idle_fired   = r_out.idle_fired;
    assign o_res.frame_missed = r_out.frame_missed;

    // a stalled result is never dropped
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |=> r_out_valid)
        else $error("result item lost while stalled");

    // a waiting input item is kept until the step takes it
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_now)))
        else $error("input item lost while stalled");

    // display off always yields idle, zero boost, no miss
    a_disp_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_valid &&
         fabg_pkg::t_kind'(r_in_kind) == fabg_pkg::KIND_DISP_OFF)
        |=> (o_res.boost == '0 && o_res.mode == fabg_pkg::MODE_IDLE &&
             !o_res.frame_missed))
        else $error("display off result not cleared");

endmodule
`default_nettype wire

[bench/fabg_boost_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fabg_boost_checker
// Watches the register port and both channels of the boost governor, keeps
// its own copy of the governor state, works out the result of every accepted
// event and compares the results in order as they leave the block.
// ----------------------------------------------------------------------------
module fabg_boost_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [fabg_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [fabg_pkg::CFG_W-1:0]     i_cfg_data,
    fabg_evt_if                            evt,
    fabg_res_if                            res,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_results,
    output int                             o_idle_fires,
    output int                             o_misses,
    output int                             o_flings
);

    localparam int MAX_REPORTS = 10;
    localparam int NOW_W       = fabg_pkg::NOW_W;
    localparam int BOOST_W     = fabg_pkg::BOOST_W;
    localparam int CFG_W       = fabg_pkg::CFG_W;

    localparam logic [CFG_W-1:0]   DEF_FRAME_PERIOD   = 32'd16_666_666;
    localparam logic [CFG_W-1:0]   DEF_MISS_THRESHOLD = 32'd20_000_000;
    localparam logic [CFG_W-1:0]   DEF_FLING_INTERVAL = 32'd8_000_000;
    localparam logic [BOOST_W-1:0] DEF_TAP_LEVEL      = 7'd10;
    localparam logic [BOOST_W-1:0] DEF_SCROLL_LEVEL   = 7'd20;
    localparam logic [BOOST_W-1:0] DEF_FLING_LEVEL    = 7'd30;
    localparam logic [BOOST_W-1:0] DEF_BOOST_MISS     = 7'd50;
    localparam logic [BOOST_W-1:0] DEF_STEP_MAX       = 7'd10;

    fabg_pkg::t_cfg     cfg;
    fabg_pkg::t_mode    mode_now;
    logic [NOW_W-1:0]   last_commit;
    logic [NOW_W-1:0]   last_touch;
    logic [BOOST_W-1:0] boost_now;
    logic [BOOST_W-1:0] boost_target;
    logic               screen_lit;
    logic               timer_armed;

    fabg_pkg::t_res boost_results_due[$];

    int fail_total   = 0;
    int due_count    = 0;
    int results_seen = 0;
    int idle_seen    = 0;
    int miss_seen    = 0;
    int fling_seen   = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = due_count;
    assign o_results    = results_seen;
    assign o_idle_fires = idle_seen;
    assign o_misses     = miss_seen;
    assign o_flings     = fling_seen;

    // time differences wrap at the stamp width
    function automatic logic [NOW_W-1:0] elapsed(logic [NOW_W-1:0] later,
                                                 logic [NOW_W-1:0] earlier);
        return later - earlier;
    endfunction

    function automatic void step_toward_target();
        int unsigned cur;
        int unsigned tgt;
        int unsigned stp;
        cur = boost_now;
        tgt = boost_target;
        stp = cfg.step_max;
        if (tgt > cur + stp) begin
            cur = cur + stp;
        end else if (tgt + stp < cur) begin
            cur = cur - stp;
        end else begin
            cur = tgt;
        end
        boost_now = BOOST_W'(cur);
    endfunction

    function automatic logic note_commit(logic [NOW_W-1:0] t);
        logic missed;
        missed = 1'b0;
        // a stored stamp of zero means no commit seen yet
        if (last_commit != '0 &&
            elapsed(t, last_commit) > NOW_W'(cfg.miss_threshold)) begin
            boost_target = cfg.boost_miss;
            missed = 1'b1;
        end
        last_commit = t;
        timer_armed = 1'b1;
        return missed;
    endfunction

    function automatic logic take_touch(fabg_pkg::t_mode m, logic [NOW_W-1:0] t);
        logic missed;
        last_touch = t;
        mode_now = m;
        case (m)
            fabg_pkg::MODE_TAP:    boost_target = cfg.tap_level;
            fabg_pkg::MODE_SCROLL: boost_target = cfg.scroll_level;
            default:               boost_target = cfg.fling_level;
        endcase
        missed = note_commit(t);
        step_toward_target();
        return missed;
    endfunction

    function automatic fabg_pkg::t_res advance_governor(logic [2:0] kind,
                                                        logic [NOW_W-1:0] t);
        fabg_pkg::t_res r;
        logic expired;
        logic missed;
        expired = 1'b0;
        missed = 1'b0;
        // idle expiry is checked ahead of the event itself
        if (timer_armed && elapsed(t, last_commit) >= NOW_W'(cfg.frame_period)) begin
            mode_now = fabg_pkg::MODE_IDLE;
            boost_target = '0;
            step_toward_target();
            timer_armed = 1'b0;
            expired = 1'b1;
        end
        case (kind)
            fabg_pkg::KIND_TOUCH_DOWN: begin
                if (screen_lit) missed = take_touch(fabg_pkg::MODE_TAP, t);
            end
            fabg_pkg::KIND_TOUCH_MOVE: begin
                if (screen_lit) begin
                    if (last_touch != '0 &&
                        elapsed(t, last_touch) < NOW_W'(cfg.fling_interval)) begin
                        missed = take_touch(fabg_pkg::MODE_FLING, t);
                    end else begin
                        missed = take_touch(fabg_pkg::MODE_SCROLL, t);
                    end
                end
            end
            fabg_pkg::KIND_COMMIT: begin
                missed = note_commit(t);
                step_toward_target();
            end
            fabg_pkg::KIND_DISP_ON: begin
                screen_lit = 1'b1;
            end
            fabg_pkg::KIND_DISP_OFF: begin
                screen_lit = 1'b0;
                mode_now = fabg_pkg::MODE_IDLE;
                boost_now = '0;
                boost_target = '0;
                timer_armed = 1'b0;
            end
            default: ;  // tick and the unused kinds
        endcase
        r.boost = boost_now;
        r.mode = mode_now;
        r.idle_fired = expired;
        r.frame_missed = missed;
        return r;
    endfunction

    always @(posedge i_clk) begin
        fabg_pkg::t_res got;
        fabg_pkg::t_res want;
        if (!i_rst_n) begin
            cfg.frame_period   = DEF_FRAME_PERIOD;
            cfg.miss_threshold = DEF_MISS_THRESHOLD;
            cfg.fling_interval = DEF_FLING_INTERVAL;
            cfg.tap_level      = DEF_TAP_LEVEL;
            cfg.scroll_level   = DEF_SCROLL_LEVEL;
            cfg.fling_level    = DEF_FLING_LEVEL;
            cfg.boost_miss     = DEF_BOOST_MISS;
            cfg.step_max       = DEF_STEP_MAX;
            mode_now     = fabg_pkg::MODE_IDLE;
            last_commit  = '0;
            last_touch   = '0;
            boost_now    = '0;
            boost_target = '0;
            screen_lit   = 1'b0;
            timer_armed  = 1'b0;
            boost_results_due.delete();
            due_count = 0;
        end else begin
            // compare before queuing, a result never belongs to this edge's event
            if (res.valid === 1'b1 && res.ready === 1'b1) begin
                results_seen++;
                got.boost = res.boost;
                got.mode = fabg_pkg::t_mode'(res.mode);
                got.idle_fired = res.idle_fired;
                got.frame_missed = res.frame_missed;
                if (boost_results_due.size() == 0) begin
                    fail_total++;
                    if (fail_total <= MAX_REPORTS)
                        $display("%0t: result with no event waiting: %s %0d %0d %0b %0b",
                                 $time, "boost/mode/idle/miss", got.boost, got.mode,
                                 got.idle_fired, got.frame_missed);
                end else begin
                    want = boost_results_due.pop_front();
                    if (got.boost !== want.boost || got.mode !== want.mode ||
                        got.idle_fired !== want.idle_fired ||
                        got.frame_missed !== want.frame_missed) begin
                        fail_total++;
                        if (fail_total <= MAX_REPORTS)
                            $display({"%0t: result %0d mismatch: expected boost %0d ",
                                      "mode %0d idle %0b miss %0b, got boost %0d ",
                                      "mode %0d idle %0b miss %0b"},
                                     $time, results_seen, want.boost, want.mode,
                                     want.idle_fired, want.frame_missed, got.boost,
                                     got.mode, got.idle_fired, got.frame_missed);
                    end
                end
            end
            if (evt.valid === 1'b1 && evt.ready === 1'b1) begin
                want = advance_governor(evt.kind, evt.now);
                boost_results_due.push_back(want);
                if (want.idle_fired) idle_seen++;
                if (want.frame_missed) miss_seen++;
                if (evt.kind == fabg_pkg::KIND_TOUCH_MOVE &&
                    want.mode == fabg_pkg::MODE_FLING) fling_seen++;
            end
            if (i_cfg_we === 1'b1) begin
                case (i_cfg_idx)
                    fabg_pkg::REG_FRAME_PERIOD:   cfg.frame_period   = i_cfg_data;
                    fabg_pkg::REG_MISS_THRESHOLD: cfg.miss_threshold = i_cfg_data;
                    fabg_pkg::REG_FLING_INTERVAL: cfg.fling_interval = i_cfg_data;
                    fabg_pkg::REG_TAP_LEVEL:
                        cfg.tap_level    = i_cfg_data[BOOST_W-1:0];
                    fabg_pkg::REG_SCROLL_LEVEL:
                        cfg.scroll_level = i_cfg_data[BOOST_W-1:0];
                    fabg_pkg::REG_FLING_LEVEL:
                        cfg.fling_level  = i_cfg_data[BOOST_W-1:0];
                    fabg_pkg::REG_BOOST_MISS:
                        cfg.boost_miss   = i_cfg_data[BOOST_W-1:0];
                    fabg_pkg::REG_STEP_MAX:
                        cfg.step_max     = i_cfg_data[BOOST_W-1:0];
                    default: ;
                endcase
            end
            due_count = boost_results_due.size();
        end
    end

endmodule

[bench/tb_frame_aware_boost_governor.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_frame_aware_boost_governor
// Drives timestamped events into the boost governor in random bursts while
// the result side stalls on its own pattern. A directed opening walks the
// touch modes, idle expiry, missed frames, display on/off and time wrap;
// random phases follow under reset, all-zero, all-ones and random register
// settings. The checker beside the block judges every result.
// ----------------------------------------------------------------------------
module tb_frame_aware_boost_governor;

    localparam int NOW_W     = fabg_pkg::NOW_W;
    localparam int BOOST_W   = fabg_pkg::BOOST_W;
    localparam int CFG_W     = fabg_pkg::CFG_W;
    localparam int CFG_IDX_W = fabg_pkg::CFG_IDX_W;

    localparam int RUN_LIMIT_NS = 5_000_000;
    localparam int DRAIN_CYCLES = 4;
    localparam int MAX_GAP      = 8;

    localparam logic [2:0] KIND_SPARE_LO = 3'd6;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;

    typedef enum int {STALL_NONE, STALL_COIN, STALL_SPARSE, STALL_BURSTY} t_stall;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    fabg_evt_if evt_if ();
    fabg_res_if res_if ();

    int fail_count;
    int pending;
    int results_seen;
    int idle_seen;
    int miss_seen;
    int fling_seen;

    fabg_pkg::t_cfg   drv_cfg;
    logic [NOW_W-1:0] stamp;
    logic             screen_lit;
    int               burst_left;
    int               events_sent;
    int               cfg_sets;

    frame_aware_boost_governor dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_evt      (evt_if.sink),
        .o_res      (res_if.source)
    );

    fabg_boost_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .evt          (evt_if),
        .res          (res_if),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results_seen),
        .o_idle_fires (idle_seen),
        .o_misses     (miss_seen),
        .o_flings     (fling_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("run limit of %0d ns reached with %0d results outstanding",
                 RUN_LIMIT_NS, pending);
        $display("tb_frame_aware_boost_governor: FAIL");
        $finish;
    end

    // result side back-pressure, in stall styles drawn at random
    initial begin
        t_stall style;
        int     left;
        int     beat;
        res_if.ready <= 1'b0;
        style = STALL_NONE;
        left = 0;
        beat = 0;
        forever begin
            @(posedge i_clk);
            if (left == 0) begin
                style = t_stall'($urandom_range(0, 3));
                left = $urandom_range(50, 300);
            end
            left--;
            beat++;
            case (style)
                STALL_NONE:   res_if.ready <= 1'b1;
                STALL_COIN:   res_if.ready <= ($urandom_range(0, 1) == 1);
                STALL_SPARSE: res_if.ready <= (beat % 4 == 0);
                default:      res_if.ready <= (beat % 16 >= 9);
            endcase
        end
    end

    task automatic send_event(logic [2:0] kind, logic [NOW_W-1:0] t);
        evt_if.valid <= 1'b1;
        evt_if.kind <= kind;
        evt_if.now <= t;
        do @(posedge i_clk); while (evt_if.ready !== 1'b1);
        events_sent++;
        if (kind == fabg_pkg::KIND_DISP_ON) screen_lit = 1'b1;
        else if (kind == fabg_pkg::KIND_DISP_OFF) screen_lit = 1'b0;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            evt_if.valid <= 1'b0;
            repeat ($urandom_range(1, MAX_GAP)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 80)
                                                     : $urandom_range(0, 6);
        end
    endtask

    // hold the sender until every result is out and the pipe is empty
    task automatic drain_results();
        evt_if.valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic program_governor(fabg_pkg::t_cfg c);
        logic [CFG_W-1:0] junk;
        junk = $urandom;
        write_reg(fabg_pkg::REG_FRAME_PERIOD, c.frame_period);
        write_reg(fabg_pkg::REG_MISS_THRESHOLD, c.miss_threshold);
        write_reg(fabg_pkg::REG_FLING_INTERVAL, c.fling_interval);
        // narrow registers get random upper bits that must be dropped
        write_reg(fabg_pkg::REG_TAP_LEVEL, {junk[CFG_W-1:BOOST_W], c.tap_level});
        write_reg(fabg_pkg::REG_SCROLL_LEVEL, {junk[CFG_W-1:BOOST_W], c.scroll_level});
        write_reg(fabg_pkg::REG_FLING_LEVEL, {junk[CFG_W-1:BOOST_W], c.fling_level});
        write_reg(fabg_pkg::REG_BOOST_MISS, {junk[CFG_W-1:BOOST_W], c.boost_miss});
        write_reg(fabg_pkg::REG_STEP_MAX, {junk[CFG_W-1:BOOST_W], c.step_max});
        // an unmapped index must leave everything alone
        write_reg(CFG_IDX_W'($urandom_range(int'(fabg_pkg::REG_STEP_MAX) + 1,
                                            (1 << CFG_IDX_W) - 1)),
                  $urandom);
        i_cfg_we <= 1'b0;
        drv_cfg = c;
        cfg_sets++;
    endtask

    task automatic random_events(int count, int pause_at);
        logic [2:0]       kind;
        logic [CFG_W-1:0] thr;
        logic [63:0]      wide;
        int               roll;
        for (int n = 0; n < count; n++) begin
            if (n == pause_at) drain_results();
            roll = $urandom_range(0, 99);
            if (!screen_lit && roll < 40) kind = fabg_pkg::KIND_DISP_ON;
            else if (roll < 14) kind = fabg_pkg::KIND_TICK;
            else if (roll < 30) kind = fabg_pkg::KIND_TOUCH_DOWN;
            else if (roll < 55) kind = fabg_pkg::KIND_TOUCH_MOVE;
            else if (roll < 88) kind = fabg_pkg::KIND_COMMIT;
            else if (roll < 93) kind = fabg_pkg::KIND_DISP_ON;
            else if (roll < 97) kind = fabg_pkg::KIND_DISP_OFF;
            else kind = roll[0] ? KIND_SPARE_LO : KIND_SPARE_HI;

            // step the clock relative to one of the live thresholds
            case ($urandom_range(0, 2))
                0:       thr = drv_cfg.frame_period;
                1:       thr = drv_cfg.miss_threshold;
                default: thr = drv_cfg.fling_interval;
            endcase
            case ($urandom_range(0, 19))
                0, 1, 2, 3:
                    stamp = stamp + NOW_W'(thr) + NOW_W'($urandom_range(0, 2)) - 1;
                4, 5, 6, 7, 8:
                    stamp = stamp + NOW_W'($urandom_range(0, thr));
                9, 10, 11:
                    stamp = stamp + NOW_W'(thr) + NOW_W'($urandom_range(0, thr));
                12, 13:
                    stamp = stamp + NOW_W'($urandom_range(0, 1000));
                14: ;
                15:
                    stamp = stamp - NOW_W'($urandom_range(1, 1_000_000));
                16:
                    stamp = '0;
                17:
                    stamp = '1 - NOW_W'($urandom_range(0, 1000));
                default: begin
                    wide = {$urandom, $urandom};
                    stamp = wide[NOW_W-1:0];
                end
            endcase
            send_event(kind, stamp);
        end
        drain_results();
    endtask

    function automatic logic [CFG_W-1:0] random_span();
        case ($urandom_range(0, 7))
            0:       return $urandom;
            1:       return $urandom_range(0, 100);
            default: return $urandom_range(1000, 50_000_000);
        endcase
    endfunction

    function automatic logic [BOOST_W-1:0] random_level();
        if ($urandom_range(0, 9) == 0) return '1;
        return BOOST_W'($urandom_range(0, 100));
    endfunction

    initial begin
        fabg_pkg::t_cfg   c;
        logic [NOW_W-1:0] t;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= '0;
        i_cfg_data <= '0;
        evt_if.valid <= 1'b0;
        evt_if.kind <= fabg_pkg::KIND_TICK;
        evt_if.now <= '0;
        drv_cfg.frame_period   = 32'd16_666_666;
        drv_cfg.miss_threshold = 32'd20_000_000;
        drv_cfg.fling_interval = 32'd8_000_000;
        drv_cfg.tap_level      = 7'd10;
        drv_cfg.scroll_level   = 7'd20;
        drv_cfg.fling_level    = 7'd30;
        drv_cfg.boost_miss     = 7'd50;
        drv_cfg.step_max       = 7'd10;
        stamp = '0;
        screen_lit = 1'b0;
        burst_left = 0;
        events_sent = 0;
        cfg_sets = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed opening under the reset settings
        t = 48'd1_000_000;
        send_event(fabg_pkg::KIND_TICK, t);             // timer not armed yet
        send_event(fabg_pkg::KIND_TOUCH_DOWN, t + 100); // display off: ignored
        send_event(fabg_pkg::KIND_TOUCH_MOVE, t + 200);
        send_event(fabg_pkg::KIND_DISP_ON, t + 300);
        t = t + 1000;
        send_event(fabg_pkg::KIND_TOUCH_DOWN, t);       // tap, first commit ever
        t = t + 2_000_000;
        send_event(fabg_pkg::KIND_TOUCH_MOVE, t);       // fling
        t = t + NOW_W'(drv_cfg.fling_interval);
        send_event(fabg_pkg::KIND_TOUCH_MOVE, t);       // right at the interval: scroll
        t = t + 5_000_000;
        send_event(fabg_pkg::KIND_COMMIT, t);
        t = t + NOW_W'(drv_cfg.frame_period);
        send_event(fabg_pkg::KIND_TICK, t);             // expiry right at the period
        t = t + 30_000_000;
        send_event(fabg_pkg::KIND_COMMIT, t);           // late frame
        t = t + NOW_W'(drv_cfg.miss_threshold);
        send_event(fabg_pkg::KIND_COMMIT, t);           // gap equal to threshold is on time
        send_event(fabg_pkg::KIND_COMMIT, t - 5000);    // earlier stamp wraps around
        send_event(KIND_SPARE_LO, t);
        send_event(KIND_SPARE_HI, t);
        send_event(fabg_pkg::KIND_COMMIT, '0);          // zero stamp reads as never
        send_event(fabg_pkg::KIND_COMMIT, NOW_W'(100));
        send_event(fabg_pkg::KIND_DISP_OFF, NOW_W'(200));
        send_event(fabg_pkg::KIND_TOUCH_DOWN, NOW_W'(300));
        send_event(fabg_pkg::KIND_DISP_ON, NOW_W'(400));
        send_event(fabg_pkg::KIND_TOUCH_MOVE, '1);      // top of the time range
        t = NOW_W'(16);
        send_event(fabg_pkg::KIND_TOUCH_MOVE, t);       // wraps past zero: fling
        send_event(fabg_pkg::KIND_TICK, t + NOW_W'(drv_cfg.frame_period) - 1);
        send_event(fabg_pkg::KIND_TICK, t + NOW_W'(drv_cfg.frame_period));
        stamp = t + NOW_W'(drv_cfg.frame_period);

        random_events(400, 200);

        c = '0;
        program_governor(c);
        random_events(150, -1);

        c = '1;
        program_governor(c);
        random_events(150, -1);

        repeat (6) begin
            c.frame_period   = random_span();
            c.miss_threshold = random_span();
            c.fling_interval = random_span();
            c.tap_level      = random_level();
            c.scroll_level   = random_level();
            c.fling_level    = random_level();
            c.boost_miss     = random_level();
            case ($urandom_range(0, 7))
                0:       c.step_max = '0;
                1:       c.step_max = '1;
                default: c.step_max = BOOST_W'($urandom_range(1, 100));
            endcase
            program_governor(c);
            random_events(220, -1);
        end

        $display("run covered %0d events under %0d register settings, %0d results checked",
                 events_sent, cfg_sets + 1, results_seen);
        $display("idle expiries %0d, missed frames %0d, fling moves %0d, mismatches %0d",
                 idle_seen, miss_seen, fling_seen, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_frame_aware_boost_governor: PASS");
        end else begin
            $display("tb_frame_aware_boost_governor: FAIL");
        end
        $finish;
    end

endmodule
